>>> rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the rotating card deck: request and
// response payloads, request and status codes, controller commands.
// ----------------------------------------------------------------------------
package rcd_pkg;

    // Default geometry of the ring store
    localparam int DECK_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF   = 16;

    // Width of the identifier fields on the channels
    localparam int FIELD_ID_W = 16;

    typedef enum logic [1:0] {
        REQ_ADD           = 2'd0,
        REQ_REMOVE        = 2'd1,
        REQ_TOP_TO_BOTTOM = 2'd2,
        REQ_BOTTOM_TO_TOP = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_TOO_FEW = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t                     req_type;
        logic signed [FIELD_ID_W-1:0]  card_id;
    } req_payload_t;

    typedef struct packed {
        status_t                       status;
        logic signed [FIELD_ID_W-1:0]  removed_id;
        logic                          deck_empty;
    } rsp_payload_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_FIN  = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;    // latch request, issue store read
        logic commit;  // write back, move pointers, load response
    } ctrl_cmd_t;

endpackage

>>> rtl/rcd_chan_if.sv
// ----------------------------------------------------------------------------
// rcd_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface rcd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/rcd_ctrl.sv
// ----------------------------------------------------------------------------
// rcd_ctrl
// Sequencer for the card deck: take a request, wait for the store read,
// then commit once the response register is free.
// ----------------------------------------------------------------------------
module rcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output rcd_pkg::ctrl_cmd_t cmd
);
    import rcd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        slot_free      = !out_valid_reg || out_ready;
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.take       = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the response register can take the beat
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/rcd_dp.sv
// ----------------------------------------------------------------------------
// rcd_dp
// Deck datapath: ring store, top index and count registers, request
// latch and response register.
// ----------------------------------------------------------------------------
module rcd_dp #(
    parameter int DEPTH = rcd_pkg::DECK_DEPTH_DEF,
    parameter int IW    = rcd_pkg::ID_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcd_pkg::ctrl_cmd_t    cmd,
    input  rcd_pkg::req_payload_t in_data,
    output rcd_pkg::rsp_payload_t out_data
);
    import rcd_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

    logic [IW-1:0]    mem [DEPTH];

    logic [IDX_W-1:0] top_reg;
    logic [IDX_W-1:0] top_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    req_payload_t     req_reg;
    logic [IW-1:0]    rdata_reg;
    rsp_payload_t     rsp_reg;
    rsp_payload_t     rsp_next;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] bottom;
    logic [IDX_W-1:0] prev_top;
    logic [IDX_W-1:0] top_inc;
    logic [IDX_W-1:0] below;
    logic [SUM_W-1:0] top_ext;
    logic [SUM_W-1:0] cnt_ext;
    logic [SUM_W-1:0] cnt_m1;
    logic             full;
    logic             few;
    logic             empty;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IW-1:0]    wr_data;

    // Fold a sum below twice the depth back into the ring
    function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return r[IDX_W-1:0];
    endfunction

    always_comb
    begin
        top_ext  = SUM_W'(top_reg);
        cnt_ext  = SUM_W'(count_reg);
        cnt_m1   = (count_reg == '0) ? '0 : (cnt_ext - SUM_W'(1));
        bottom   = ring_wrap(top_ext + cnt_m1);
        below    = ring_wrap(top_ext + cnt_ext);
        top_inc  = ring_wrap(top_ext + SUM_W'(1));
        prev_top = (top_reg == '0) ? IDX_W'(DEPTH - 1) : (top_reg - IDX_W'(1));
        full     = (count_reg == CNT_W'(DEPTH));
        few      = (count_reg < CNT_W'(2));
        empty    = (count_reg == '0);
        rd_addr  = (in_data.req_type == REQ_BOTTOM_TO_TOP) ? bottom : top_reg;
    end

    // Work out the step from the latched request and the read data
    always_comb
    begin
        rsp_next.status     = ST_DONE;
        rsp_next.removed_id = '0;
        wr_en               = 1'b0;
        wr_addr             = top_reg;
        wr_data             = rdata_reg;
        top_next            = top_reg;
        count_next          = count_reg;
        case (req_reg.req_type)
            REQ_ADD:
            begin
                if (full)
                    rsp_next.status = ST_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = prev_top;
                    wr_data    = IW'($unsigned(req_reg.card_id));
                    top_next   = prev_top;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                if (empty)
                    rsp_next.status = ST_TOO_FEW;
                else
                begin
                    rsp_next.removed_id = FIELD_ID_W'(rdata_reg);
                    top_next            = top_inc;
                    count_next          = count_reg - CNT_W'(1);
                end
            end
            REQ_TOP_TO_BOTTOM:
            begin
                if (few)
                    rsp_next.status = ST_TOO_FEW;
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = below;
                    top_next = top_inc;
                end
            end
            REQ_BOTTOM_TO_TOP:
            begin
                if (few)
                    rsp_next.status = ST_TOO_FEW;
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = prev_top;
                    top_next = prev_top;
                end
            end
            default:
            begin
                rsp_next.status = ST_TOO_FEW;
            end
        endcase
        rsp_next.deck_empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            top_reg   <= top_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            req_reg <= in_data;
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            rdata_reg <= mem[rd_addr];
    end

    assign out_data = rsp_reg;

endmodule

>>> rtl/rotating_card_deck.sv
// ----------------------------------------------------------------------------
// rotating_card_deck
// Sequence: a taken request and its store read data are registered; then
// the commit loads the response register once it is free, and the response
// beat turns valid; the registered store read port sets this order.
// Flow: a new request is taken only after the previous one has committed;
// a waiting response stalls the next commit, not the next request beat.
// Reset: top index and card count clear at once; the store is not cleared.
// ----------------------------------------------------------------------------
module rotating_card_deck #(
    parameter int DECK_DEPTH = rcd_pkg::DECK_DEPTH_DEF,
    parameter int ID_WIDTH   = rcd_pkg::ID_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rcd_chan_if.sink    req,
    rcd_chan_if.source  rsp
);
    import rcd_pkg::*;

    ctrl_cmd_t    cmd;
    logic         in_ready;
    logic         out_valid;
    rsp_payload_t rsp_data;

    // Controller: sequences take, read and commit, and owns the response
    // valid flag so the request side keeps flowing while a beat waits.
    rcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Datapath: ring store, pointer registers and the response register.
    rcd_dp #(
        .DEPTH (DECK_DEPTH),
        .IW    (ID_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (req.data),
        .out_data (rsp_data)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    assign rsp.data  = rsp_data;

    // One request in flight: after a take, drop ready until the commit.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> !in_ready)
        else $error("request taken while another is in flight");

    // A commit always presents a response beat on the next cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit did not load a response beat");

    // Only a successful remove returns a non-zero identifier.
    a_removed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.removed_id != '0) |-> rsp.data.status == ST_DONE)
        else $error("identifier returned on a refused request");

    // A full deck cannot report itself empty.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == ST_FULL) |-> !rsp.data.deck_empty)
        else $error("full refusal with empty deck");

endmodule
